// ===== hdl/gamm_pkg.sv =====
// Shared types, constants and width helpers for the grid activity motor map.
`default_nettype none

package gamm_pkg;

    localparam int CELL_BITS    = 16;
    localparam int DEF_MAX_EDGE = 16;
    localparam int SPEED_W      = 11;
    localparam int EDGE_CFG_W   = 5;
    localparam int CFG_DATA_W   = 11;
    localparam int OUT_W        = 20;
    localparam int SPEED_LIMIT  = 262144;
    localparam int MIN_EDGE     = 2;

    localparam logic MODE_QUADRANT = 1'b0;
    localparam logic MODE_PEAK     = 1'b1;

    localparam logic                  MODE_RESET  = MODE_PEAK;
    localparam logic [SPEED_W-1:0]    SPEED_RESET = 11'd255;
    localparam logic [EDGE_CFG_W-1:0] EDGE_RESET  = 5'd4;

    typedef enum logic [1:0] {
        REG_MAP_MODE    = 2'd0,
        REG_SPEED_MAX   = 2'd1,
        REG_EDGE_LENGTH = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [CELL_BITS-1:0] cell_value;
        logic                 last_cell;
    } cell_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] left_speed;
        logic signed [OUT_W-1:0] right_speed;
    } speed_item_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Side length and grid positions, up to and including the edge itself.
    function automatic int edge_w(input int me);
        return $clog2(me + 1);
    endfunction

    function automatic int cnt_w(input int me);
        return $clog2(me * me + 1);
    endfunction

    function automatic int psum_w(input int me);
        return $clog2(me * me * (me - 1) + 1);
    endfunction

    // A quadrant holds at most ceil(edge/2) squared cells.
    function automatic int qsum_w(input int me);
        return CELL_BITS + $clog2(((me + 1) >> 1) * ((me + 1) >> 1) + 1);
    endfunction

    function automatic int job_w(input int me);
        return 1 + SPEED_W + edge_w(me) + cnt_w(me) + 2 * psum_w(me) + 4 * qsum_w(me);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gamm_front.sv =====
// Front end: walks the grid position and accumulates quadrant and peak sums per cell.
`default_nettype none

module gamm_front #(
    parameter int MAX_EDGE = gamm_pkg::DEF_MAX_EDGE
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     take,
    input  wire gamm_pkg::cell_item_t                     item,
    input  wire logic [gamm_pkg::edge_w(MAX_EDGE)-1:0]    side,
    input  wire logic                                     map_mode,
    input  wire logic [gamm_pkg::SPEED_W-1:0]             speed_max,
    output logic                                          push,
    output logic [gamm_pkg::job_w(MAX_EDGE)-1:0]          job
);
    import gamm_pkg::*;

    localparam int EW = edge_w(MAX_EDGE);
    localparam int CW = cnt_w(MAX_EDGE);
    localparam int PW = psum_w(MAX_EDGE);
    localparam int QW = qsum_w(MAX_EDGE);

    logic [EW-1:0]        row_reg, row_next;
    logic [EW-1:0]        col_reg, col_next;
    logic [QW-1:0]        quad_reg [4];
    logic [QW-1:0]        quad_next [4];
    logic [CELL_BITS-1:0] peak_val_reg, peak_val_next;
    logic [PW-1:0]        peak_col_reg, peak_col_next;
    logic [PW-1:0]        peak_row_reg, peak_row_next;
    logic [CW-1:0]        peak_cnt_reg, peak_cnt_next;

    logic [EW:0]   side_inc;
    logic [EW:0]   col_inc;
    logic [EW-1:0] h1;
    logic [EW-1:0] h0;
    logic          top, bot, lft, rgt;

    always_comb
    begin
        side_inc = {1'b0, side} + 1'b1;
        h1       = side_inc[EW:1];
        h0       = side >> 1;
        col_inc  = {1'b0, col_reg} + 1'b1;
        top      = row_reg < h1;
        bot      = row_reg >= h0;
        lft      = col_reg < h1;
        rgt      = col_reg >= h0;

        row_next      = row_reg;
        col_next      = col_reg;
        quad_next     = quad_reg;
        peak_val_next = peak_val_reg;
        peak_col_next = peak_col_reg;
        peak_row_next = peak_row_reg;
        peak_cnt_next = peak_cnt_reg;

        // Cells past the grid are dropped; the position stops just past the last row.
        if (row_reg < side)
        begin
            if (col_reg < side)
            begin
                if (top && lft) quad_next[0] = quad_reg[0] + QW'(item.cell_value);
                if (top && rgt) quad_next[1] = quad_reg[1] + QW'(item.cell_value);
                if (bot && lft) quad_next[2] = quad_reg[2] + QW'(item.cell_value);
                if (bot && rgt) quad_next[3] = quad_reg[3] + QW'(item.cell_value);

                // A new maximum restarts the centroid sums.
                if (peak_cnt_reg == '0 || item.cell_value > peak_val_reg)
                begin
                    peak_val_next = item.cell_value;
                    peak_col_next = PW'(col_reg);
                    peak_row_next = PW'(row_reg);
                    peak_cnt_next = CW'(1);
                end
                else if (item.cell_value == peak_val_reg)
                begin
                    peak_col_next = peak_col_reg + PW'(col_reg);
                    peak_row_next = peak_row_reg + PW'(row_reg);
                    peak_cnt_next = peak_cnt_reg + 1'b1;
                end
            end
            if (col_inc >= {1'b0, side})
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_inc[EW-1:0];
            end
        end
    end

    assign push = take && item.last_cell;
    assign job  = {map_mode, speed_max, side, peak_cnt_next, peak_col_next, peak_row_next,
                   quad_next[3], quad_next[2], quad_next[1], quad_next[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            quad_reg     <= '{default: '0};
            peak_val_reg <= '0;
            peak_col_reg <= '0;
            peak_row_reg <= '0;
            peak_cnt_reg <= '0;
        end
        else if (take)
        begin
            if (item.last_cell)
            begin
                row_reg      <= '0;
                col_reg      <= '0;
                quad_reg     <= '{default: '0};
                peak_val_reg <= '0;
                peak_col_reg <= '0;
                peak_row_reg <= '0;
                peak_cnt_reg <= '0;
            end
            else
            begin
                row_reg      <= row_next;
                col_reg      <= col_next;
                quad_reg     <= quad_next;
                peak_val_reg <= peak_val_next;
                peak_col_reg <= peak_col_next;
                peak_row_reg <= peak_row_next;
                peak_cnt_reg <= peak_cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gamm_queue.sv =====
// Two-entry queue that holds finished grid sums between the front and back ends.
`default_nettype none

module gamm_queue #(
    parameter int WIDTH = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  full,
    output logic                  empty
);
    import gamm_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign rdata = slot_reg[rd_ptr_reg];
    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gamm_back.sv =====
// Back end: turns one grid's sums into rounded, saturated wheel speeds with a shared divider.
`default_nettype none

module gamm_back #(
    parameter int MAX_EDGE = gamm_pkg::DEF_MAX_EDGE
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 job_ready,
    input  wire logic [gamm_pkg::job_w(MAX_EDGE)-1:0] job,
    output logic                                      pop,
    output logic                                      result_valid,
    output gamm_pkg::speed_item_t                     result
);
    import gamm_pkg::*;

    localparam int EW       = edge_w(MAX_EDGE);
    localparam int CW       = cnt_w(MAX_EDGE);
    localparam int PW       = psum_w(MAX_EDGE);
    localparam int QW       = qsum_w(MAX_EDGE);
    localparam int OP_W     = imax(CW, EW);
    localparam int MAG_W    = imax(QW, PW + 1);
    localparam int PROD_W   = MAG_W + SPEED_W;
    localparam int DEN_W    = imax(2 * EW, CW + EW);
    localparam int QBIAS_SH = CELL_BITS - 10;
    localparam int QDIV_SH  = CELL_BITS - 9;
    localparam int PEAK_SH  = 9;
    localparam int DVD_W    = imax(imax(PROD_W, DEN_W + QBIAS_SH) + 1,
                                   imax(PROD_W + PEAK_SH, DEN_W) + 1);
    localparam int DVS_W    = imax(DEN_W + QDIV_SH, DEN_W + 1);
    localparam int ITER_W   = $clog2(DVD_W + 1);

    localparam logic signed [OUT_W-1:0] SPEED_HI = OUT_W'(SPEED_LIMIT);
    localparam logic signed [OUT_W-1:0] SPEED_LO = -SPEED_HI;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_STORE
    } state_t;

    state_t               state_reg;
    logic                 mode_reg;
    logic [SPEED_W-1:0]   speed_reg;
    logic [EW-1:0]        side_reg;
    logic [CW-1:0]        cnt_reg;
    logic [PW-1:0]        sx_reg;
    logic [PW-1:0]        sy_reg;
    logic [QW-1:0]        quad_reg [4];
    logic [DEN_W-1:0]     den_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 neg_reg;
    logic                 half_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic signed [OUT_W-1:0] left_reg;
    speed_item_t          result_reg;
    logic                 result_valid_reg;

    logic [EW-1:0]        side_less;
    logic [OP_W-1:0]      opa, opb;
    logic [DEN_W-1:0]     den_next;
    logic [MAG_W-1:0]     a_val, b_val, mag;
    logic                 neg;
    logic [PROD_W-1:0]    prod;
    logic [DVD_W-1:0]     dvd_load;
    logic [DVS_W-1:0]     dvs_load;
    logic [DVS_W:0]       rem_sh;
    logic [DVS_W:0]       diff;
    logic                 ge;
    logic [OUT_W-1:0]     sat;
    logic signed [OUT_W-1:0] speed_val;

    always_comb
    begin
        side_less = side_reg - 1'b1;

        // Quadrant mode divides by L*L, peak mode by n*(L-1).
        if (mode_reg == MODE_PEAK)
        begin
            opa = OP_W'(cnt_reg);
            opb = OP_W'(side_less);
        end
        else
        begin
            opa = OP_W'(side_reg);
            opb = OP_W'(side_reg);
        end
        den_next = DEN_W'(opa) * DEN_W'(opb);

        if (mode_reg == MODE_PEAK)
        begin
            if (!half_reg)
            begin
                a_val = MAG_W'(sx_reg);
                b_val = MAG_W'(sy_reg);
            end
            else
            begin
                a_val = MAG_W'(den_reg);
                b_val = MAG_W'(sx_reg) + MAG_W'(sy_reg);
            end
        end
        else
        begin
            a_val = MAG_W'(half_reg ? quad_reg[1] : quad_reg[0]);
            b_val = MAG_W'(half_reg ? quad_reg[3] : quad_reg[2]);
        end
        neg  = b_val > a_val;
        mag  = neg ? (b_val - a_val) : (a_val - b_val);
        prod = PROD_W'(mag) * PROD_W'(speed_reg);

        // Round to nearest is folded into the dividend as half the divisor.
        if (mode_reg == MODE_PEAK)
        begin
            dvd_load = (DVD_W'(prod_reg) << PEAK_SH) + DVD_W'(den_reg);
            dvs_load = DVS_W'(den_reg) << 1;
        end
        else
        begin
            dvd_load = DVD_W'(prod_reg) + (DVD_W'(den_reg) << QBIAS_SH);
            dvs_load = DVS_W'(den_reg) << QDIV_SH;
        end

        rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        ge     = rem_sh >= {1'b0, dvs_reg};

        sat       = (dvd_reg > DVD_W'(SPEED_LIMIT)) ? OUT_W'(SPEED_LIMIT) : OUT_W'(dvd_reg);
        speed_val = neg_reg ? -$signed(sat) : $signed(sat);
    end

    assign pop          = (state_reg == ST_IDLE) && job_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mode_reg         <= 1'b0;
            speed_reg        <= '0;
            side_reg         <= '0;
            cnt_reg          <= '0;
            sx_reg           <= '0;
            sy_reg           <= '0;
            quad_reg         <= '{default: '0};
            den_reg          <= '0;
            prod_reg         <= '0;
            neg_reg          <= 1'b0;
            half_reg         <= 1'b0;
            dvd_reg          <= '0;
            dvs_reg          <= '0;
            rem_reg          <= '0;
            iter_reg         <= '0;
            left_reg         <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_ready)
                    begin
                        {mode_reg, speed_reg, side_reg, cnt_reg, sx_reg, sy_reg,
                         quad_reg[3], quad_reg[2], quad_reg[1], quad_reg[0]} <= job;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    den_reg  <= den_next;
                    half_reg <= 1'b0;
                    // A grid with no accepted cell has no peak: both speeds are zero.
                    if (mode_reg == MODE_PEAK && cnt_reg == '0)
                    begin
                        result_reg       <= '0;
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= prod;
                    neg_reg   <= neg;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    dvd_reg   <= dvd_load;
                    dvs_reg   <= dvs_load;
                    rem_reg   <= '0;
                    iter_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg  <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                    dvd_reg  <= {dvd_reg[DVD_W-2:0], ge};
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(DVD_W - 1))
                    begin
                        state_reg <= ST_STORE;
                    end
                end
                ST_STORE:
                begin
                    if (!half_reg)
                    begin
                        left_reg  <= speed_val;
                        half_reg  <= 1'b1;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        result_reg.left_speed  <= left_reg;
                        result_reg.right_speed <= speed_val;
                        result_valid_reg       <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result strobe held for more than one cycle");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

    a_speed_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.left_speed <= SPEED_HI)
                          && (result_reg.left_speed >= SPEED_LO)
                          && (result_reg.right_speed <= SPEED_HI)
                          && (result_reg.right_speed >= SPEED_LO))
        else $error("wheel speed outside saturation range");

endmodule

`default_nettype wire

// ===== hdl/grid_activity_motor_map.sv =====
// Top level: configuration registers, grid accumulator, sum queue and speed divider.
// Cells are taken one per cycle while busy is low; busy rises only when two finished
// grids wait in the queue. Each result comes from two passes of the one-bit-per-cycle
// restoring divider in the back end.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset is asynchronous: registers go to peak mode, speed 255, edge 4, sums clear.
`default_nettype none

module grid_activity_motor_map #(
    parameter int MAX_EDGE = gamm_pkg::DEF_MAX_EDGE
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire gamm_pkg::cell_item_t              item,
    output logic                                   result_valid,
    output gamm_pkg::speed_item_t                  result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire gamm_pkg::cfg_index_t              cfg_index,
    input  wire logic [gamm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gamm_pkg::*;

    localparam int EW    = edge_w(MAX_EDGE);
    localparam int JOB_W = job_w(MAX_EDGE);

    logic                  map_mode_reg;
    logic [SPEED_W-1:0]    speed_max_reg;
    logic [EDGE_CFG_W-1:0] edge_length_reg;

    logic [EW-1:0]    side;
    logic             take;
    logic             push;
    logic [JOB_W-1:0] job_in;
    logic [JOB_W-1:0] job_out;
    logic             pop;
    logic             q_full;
    logic             q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mode_reg    <= MODE_RESET;
            speed_max_reg   <= SPEED_RESET;
            edge_length_reg <= EDGE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAP_MODE:    map_mode_reg    <= cfg_data[0];
                REG_SPEED_MAX:   speed_max_reg   <= cfg_data[SPEED_W-1:0];
                REG_EDGE_LENGTH: edge_length_reg <= cfg_data[EDGE_CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    // Side length clamped into the supported range.
    always_comb
    begin
        if (edge_length_reg < EDGE_CFG_W'(MIN_EDGE))
            side = EW'(MIN_EDGE);
        else if (int'(edge_length_reg) > MAX_EDGE)
            side = EW'(MAX_EDGE);
        else
            side = EW'(edge_length_reg);
    end

    assign busy = q_full;
    assign take = start && !q_full;

    gamm_front #(
        .MAX_EDGE (MAX_EDGE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .side      (side),
        .map_mode  (map_mode_reg),
        .speed_max (speed_max_reg),
        .push      (push),
        .job       (job_in)
    );

    gamm_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job_in),
        .pop   (pop),
        .rdata (job_out),
        .full  (q_full),
        .empty (q_empty)
    );

    gamm_back #(
        .MAX_EDGE (MAX_EDGE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_ready    (!q_empty),
        .job          (job_out),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
